/* rtl/kdlp_pkg.sv */
// Shared types and constants for the keypad debounce / long-press code FIFO.
// No dependencies; imported by kdlp_scan and the top level.
package kdlp_pkg;

    localparam int KeyW    = 32;
    localparam int TimerW  = 16;
    localparam int CfgIdxW = 2;
    localparam int CountW  = 4;

    // Reset value of the first-delay register, also the hold timer's reset value
    localparam logic [TimerW-1:0] FirstDelayRst   = 16'd33;
    localparam logic [TimerW-1:0] RepeatPeriodRst = 16'd10;

    // Item command codes
    typedef enum logic {
        CMD_TICK = 1'b0,
        CMD_READ = 1'b1
    } t_cmd;

    // Configuration register indexes
    localparam logic [CfgIdxW-1:0] CFG_LONG_MASK     = 2'd0;
    localparam logic [CfgIdxW-1:0] CFG_SHIFT_MASK    = 2'd1;
    localparam logic [CfgIdxW-1:0] CFG_FIRST_DELAY   = 2'd2;
    localparam logic [CfgIdxW-1:0] CFG_REPEAT_PERIOD = 2'd3;

    // Configuration seen by the scan logic
    typedef struct packed {
        logic [KeyW-1:0]   long_mask;
        logic [KeyW-1:0]   shift_mask;
        logic [TimerW-1:0] first_delay;
        logic [TimerW-1:0] repeat_period;
    } t_cfg;

    // Code push request from the scan logic to the FIFO
    typedef struct packed {
        logic            req;
        logic [KeyW-1:0] code;
    } t_push;

endpackage

/* rtl/kdlp_scan.sv */
// Debounce, release detection, hold timer and shift latch for one scan tick.
// Depends on kdlp_pkg; produces at most one code push per tick.
module kdlp_scan (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_tick,
    input  logic [kdlp_pkg::KeyW-1:0]   i_raw,
    input  kdlp_pkg::t_cfg              i_cfg,
    output kdlp_pkg::t_push             o_push
);
    import kdlp_pkg::*;

    logic [KeyW-1:0]   r_prev_raw, n_prev_raw;
    logic [KeyW-1:0]   r_prev_deb, n_prev_deb;
    logic [KeyW-1:0]   r_long_done, n_long_done;
    logic [KeyW-1:0]   r_shift_latch, n_shift_latch;
    logic [TimerW-1:0] r_timer, n_timer;

    logic [KeyW-1:0]   now_keys;
    logic [KeyW-1:0]   released;
    logic [TimerW-1:0] timer_dec;
    logic [KeyW-1:0]   latch_tgl;

    // Two-sample debounce: a bit moves only when both samples agree
    assign now_keys  = (r_prev_raw & i_raw) | (r_prev_deb & (r_prev_raw ^ i_raw));
    assign released  = r_prev_deb & ~now_keys;
    assign timer_dec = r_timer - 1'b1;
    assign latch_tgl = r_shift_latch ^ (released & i_cfg.shift_mask);

    // Next state and push request
    always_comb begin
        n_prev_raw    = i_raw;
        n_prev_deb    = now_keys;
        n_long_done   = r_long_done;
        n_shift_latch = r_shift_latch;
        n_timer       = i_cfg.first_delay;
        o_push.req    = 1'b0;
        o_push.code   = '0;

        // steady non-empty hold: count down, emit repeat or long code on expiry
        if (now_keys == r_prev_deb && now_keys != '0) begin
            n_timer = timer_dec;
            if (timer_dec == '0) begin
                if ((now_keys & ~i_cfg.long_mask) != '0) begin
                    o_push.req  = 1'b1;
                    o_push.code = now_keys | r_shift_latch;
                end else if ((now_keys & i_cfg.long_mask & ~r_long_done) != '0) begin
                    o_push.req  = 1'b1;
                    o_push.code = ~(now_keys | r_shift_latch);
                end
                n_timer     = i_cfg.repeat_period;
                n_long_done = now_keys;
            end
        end

        // release: code unless it closes a hold that already emitted one
        if (released != '0) begin
            if ((released & ~r_long_done) != '0) begin
                n_shift_latch = latch_tgl;
                o_push.req    = 1'b1;
                o_push.code   = released | latch_tgl;
            end else begin
                n_long_done = '0;
            end
        end

        if (!i_tick) begin
            o_push.req = 1'b0;
        end
    end

    // State registers, updated on accepted ticks only
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_raw    <= '0;
            r_prev_deb    <= '0;
            r_long_done   <= '0;
            r_shift_latch <= '0;
            r_timer       <= FirstDelayRst;
        end else if (i_tick) begin
            r_prev_raw    <= n_prev_raw;
            r_prev_deb    <= n_prev_deb;
            r_long_done   <= n_long_done;
            r_shift_latch <= n_shift_latch;
            r_timer       <= n_timer;
        end
    end

endmodule

/* rtl/keypad_debounce_long_press_fifo.sv */
// Top level: config registers, code FIFO memory, two-stage result pipeline.
// Depends on kdlp_pkg and kdlp_scan.
//
// Keypad scanner with debounce, hold-repeat and long-press codes feeding a
// drop-oldest code FIFO. Each beat is either a scan tick (i_cmd = 0) carrying
// the raw key bitmap, or a read (i_cmd = 1) that pops one code. The block takes
// one beat per clock while o_stall is low and returns exactly one result beat
// per input beat, through stage 1 and the output register; the FIFO lives in a
// synchronous memory with a registered read port. While a result waits on
// o_valid, one more beat is taken before o_stall rises. The FIFO memory needs
// no clearing after reset. Configuration writes are taken every cycle (o_cfg_ready
// is tied high) and must only be issued while no beat is in flight.
module keypad_debounce_long_press_fifo #(
    parameter int FIFO_DEPTH = 8,
    parameter int KEY_COUNT  = 32
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // item input
    input  logic                           i_valid,
    output logic                           o_stall,
    input  logic                           i_cmd,
    input  logic [kdlp_pkg::KeyW-1:0]      i_raw_keys,
    // result output
    output logic                           o_valid,
    input  logic                           i_stall,
    output logic [kdlp_pkg::KeyW-1:0]      o_key_code,
    output logic                           o_code_valid,
    output logic [kdlp_pkg::CountW-1:0]    o_pending_count,
    // configuration write
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [kdlp_pkg::CfgIdxW-1:0]   i_cfg_index,
    input  logic [kdlp_pkg::KeyW-1:0]      i_cfg_data
);
    import kdlp_pkg::*;

    localparam int PtrW = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
    localparam int CntW = $clog2(FIFO_DEPTH + 1);
    localparam logic [PtrW-1:0] PtrLast = PtrW'(FIFO_DEPTH - 1);
    localparam logic [CntW-1:0] CntFull = CntW'(FIFO_DEPTH);
    localparam logic [KeyW-1:0] KeyMask = KeyW'({KEY_COUNT{1'b1}});

    function automatic logic [PtrW-1:0] ptr_inc(input logic [PtrW-1:0] p);
        return (p == PtrLast) ? '0 : p + 1'b1;
    endfunction

    // configuration registers
    t_cfg r_cfg;

    // FIFO memory and pointers
    logic [KeyW-1:0] r_mem [FIFO_DEPTH];
    logic [PtrW-1:0] r_wr_ptr, n_wr_ptr;
    logic [PtrW-1:0] r_rd_ptr, n_rd_ptr;
    logic [CntW-1:0] r_count,  n_count;
    logic [KeyW-1:0] r_rd_data;

    // pipeline stage 1 and output register
    logic              r_s1_valid;
    logic              r_s1_pop_ok;
    logic [CountW-1:0] r_s1_count;
    logic              r_out_valid;
    logic [KeyW-1:0]   r_key_code;
    logic              r_code_valid;
    logic [CountW-1:0] r_pending;

    logic    accept_in;
    logic    adv_out;
    logic    is_read;
    logic    pop_ok;
    logic    tick;
    t_push   push;

    // handshake
    assign adv_out   = !r_out_valid || !i_stall;
    assign o_stall   = r_s1_valid && !adv_out;
    assign accept_in = i_valid && !o_stall;
    assign is_read   = (i_cmd == CMD_READ);
    assign tick      = accept_in && !is_read;
    assign pop_ok    = accept_in && is_read && (r_count != '0);

    assign o_cfg_ready = 1'b1;

    // configuration write decode
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.long_mask     <= '0;
            r_cfg.shift_mask    <= '0;
            r_cfg.first_delay   <= FirstDelayRst;
            r_cfg.repeat_period <= RepeatPeriodRst;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_LONG_MASK:     r_cfg.long_mask     <= i_cfg_data;
                CFG_SHIFT_MASK:    r_cfg.shift_mask    <= i_cfg_data;
                CFG_FIRST_DELAY:   r_cfg.first_delay   <= i_cfg_data[TimerW-1:0];
                CFG_REPEAT_PERIOD: r_cfg.repeat_period <= i_cfg_data[TimerW-1:0];
                default:           r_cfg               <= r_cfg;
            endcase
        end
    end

    kdlp_scan u_scan (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_tick  (tick),
        .i_raw   (i_raw_keys & KeyMask),
        .i_cfg   (r_cfg),
        .o_push  (push)
    );

    // FIFO pointer and count update; a push into a full FIFO drops the oldest
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (pop_ok) begin
            n_rd_ptr = ptr_inc(r_rd_ptr);
            n_count  = r_count - 1'b1;
        end else if (push.req) begin
            n_wr_ptr = ptr_inc(r_wr_ptr);
            if (r_count == CntFull) begin
                n_rd_ptr = ptr_inc(r_rd_ptr);
            end else begin
                n_count = r_count + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // FIFO memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (push.req) begin
            r_mem[r_wr_ptr] <= push.code;
        end
        if (pop_ok) begin
            r_rd_data <= r_mem[r_rd_ptr];
        end
    end

    // stage 1: waits for the memory read data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (accept_in) begin
            r_s1_valid <= 1'b1;
        end else if (adv_out) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept_in) begin
            r_s1_pop_ok <= pop_ok;
            r_s1_count  <= CountW'(n_count);
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv_out) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv_out && r_s1_valid) begin
            r_key_code   <= r_s1_pop_ok ? r_rd_data : '0;
            r_code_valid <= r_s1_pop_ok;
            r_pending    <= r_s1_count;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_key_code      = r_key_code;
    assign o_code_valid    = r_code_valid;
    assign o_pending_count = r_pending;

endmodule

/* rtl/kdlp_sva.sv */
// Port-level checks for the keypad code FIFO, bound to the top level.
// Depends on kdlp_pkg and keypad_debounce_long_press_fifo.
module kdlp_sva #(
    parameter int FIFO_DEPTH = 8
) (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        o_valid,
    input logic                        i_stall,
    input logic [kdlp_pkg::KeyW-1:0]   o_key_code,
    input logic                        o_code_valid,
    input logic [kdlp_pkg::CountW-1:0] o_pending_count
);
    import kdlp_pkg::*;

    // result beat held while stalled
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_key_code) && $stable(o_code_valid))
        else $error("result beat changed under stall");

    // ticks and empty reads carry a zero code
    a_zero_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_code_valid |-> o_key_code == '0)
        else $error("non-zero code without code_valid");

    // fill level never above the FIFO depth
    a_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> int'(o_pending_count) <= FIFO_DEPTH)
        else $error("pending count above FIFO depth");

    // a successful pop leaves room for at least one code
    a_pop_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_code_valid |-> int'(o_pending_count) < FIFO_DEPTH)
        else $error("pop reported a full FIFO");

endmodule

bind keypad_debounce_long_press_fifo kdlp_sva #(.FIFO_DEPTH(FIFO_DEPTH)) u_kdlp_sva (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_valid         (o_valid),
    .i_stall         (i_stall),
    .o_key_code      (o_key_code),
    .o_code_valid    (o_code_valid),
    .o_pending_count (o_pending_count)
);

/* tb/sv/tb_top.sv */
// Self-checking testbench for the keypad debounce / long-press code FIFO.
// Depends on kdlp_pkg and keypad_debounce_long_press_fifo; needs nothing else.
`timescale 1ns / 100ps

module tb_top;
    import kdlp_pkg::*;

    localparam int FifoDepth     = 8;
    localparam int ClkHalf       = 6;
    localparam int PhaseBeats    = 105;
    localparam longint Watchdog  = 64'd400_000 * 12;

    // One result beat as seen on the output channel
    typedef struct packed {
        logic [KeyW-1:0]   key_code;
        logic              code_valid;
        logic [CountW-1:0] pending;
    } t_key_result;

    // Row of the directed stimulus table
    typedef struct packed {
        t_cmd            cmd;
        logic [KeyW-1:0] raw;
        logic [7:0]      reps;
        logic            typed;
        t_key_result     want;
    } t_dir_row;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_valid = 1'b0;
    logic                 o_stall;
    logic                 i_cmd = CMD_TICK;
    logic [KeyW-1:0]      i_raw_keys = '0;
    logic                 o_valid;
    logic                 i_stall = 1'b0;
    logic [KeyW-1:0]      o_key_code;
    logic                 o_code_valid;
    logic [CountW-1:0]    o_pending_count;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [CfgIdxW-1:0]   i_cfg_index = CFG_LONG_MASK;
    logic [KeyW-1:0]      i_cfg_data = '0;

    // Scanner state mirrored by the predictor
    logic [KeyW-1:0]   cfg_long = '0;
    logic [KeyW-1:0]   cfg_shift = '0;
    logic [TimerW-1:0] cfg_first = FirstDelayRst;
    logic [TimerW-1:0] cfg_repeat = RepeatPeriodRst;
    logic [KeyW-1:0]   last_raw = '0;
    logic [KeyW-1:0]   last_stable = '0;
    logic [KeyW-1:0]   held_done = '0;
    logic [KeyW-1:0]   shift_state = '0;
    logic [TimerW-1:0] hold_count = FirstDelayRst;
    logic [KeyW-1:0]   stored_codes[$];

    t_key_result due_results[$];
    t_dir_row    dir_rows[$];
    int          mismatch_cnt = 0;
    int          stall_left = 0;
    bit          jitter_on = 1'b1;
    bit          valid_hi = 1'b0;

    keypad_debounce_long_press_fifo #(
        .FIFO_DEPTH (FifoDepth),
        .KEY_COUNT  (KeyW)
    ) u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_cmd           (i_cmd),
        .i_raw_keys      (i_raw_keys),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_key_code      (o_key_code),
        .o_code_valid    (o_code_valid),
        .o_pending_count (o_pending_count),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    always #(ClkHalf) i_clk = ~i_clk;

    // Code store drops its oldest entry when full
    function automatic void store_code(logic [KeyW-1:0] code);
        if (stored_codes.size() >= FifoDepth) begin
            void'(stored_codes.pop_front());
        end
        stored_codes.push_back(code);
    endfunction

    // Predicts the result of one accepted beat and advances the mirrored state
    function automatic t_key_result keypad_predict(t_cmd cmd, logic [KeyW-1:0] raw);
        t_key_result     res;
        logic [KeyW-1:0] stable;
        logic [KeyW-1:0] released;
        res = '0;
        if (cmd == CMD_READ) begin
            if (stored_codes.size() != 0) begin
                res.key_code   = stored_codes.pop_front();
                res.code_valid = 1'b1;
            end
        end else begin
            // two agreeing samples move a bit, a lone odd sample is ignored
            stable   = (last_raw & raw) | (last_stable & (last_raw ^ raw));
            released = last_stable & ~stable;
            if (stable == last_stable && stable != '0) begin
                hold_count = hold_count - 16'd1;
                if (hold_count == '0) begin
                    if ((stable & ~cfg_long) != '0) begin
                        store_code(stable | shift_state);
                    end else if ((stable & cfg_long & ~held_done) != '0) begin
                        store_code(~(stable | shift_state));
                    end
                    hold_count = cfg_repeat;
                    held_done  = stable;
                end
            end else begin
                hold_count = cfg_first;
            end
            if (released != '0) begin
                if ((released & ~held_done) != '0) begin
                    shift_state = shift_state ^ (released & cfg_shift);
                    store_code(released | shift_state);
                end else begin
                    held_done = '0;
                end
            end
            last_raw    = raw;
            last_stable = stable;
        end
        res.pending = CountW'(stored_codes.size());
        return res;
    endfunction

    task automatic report_mismatch(string what, logic [KeyW-1:0] got, logic [KeyW-1:0] want);
        mismatch_cnt++;
        $display("[%0t] MISMATCH %s: got %h, expected %h", $time, what, got, want);
    endtask

    task automatic check_result();
        t_key_result want;
        if (due_results.size() == 0) begin
            report_mismatch("result beat with nothing outstanding", o_key_code, '0);
        end else begin
            want = due_results.pop_front();
            if (o_key_code !== want.key_code)
                report_mismatch("key_code", o_key_code, want.key_code);
            if (o_code_valid !== want.code_valid)
                report_mismatch("code_valid", KeyW'(o_code_valid), KeyW'(want.code_valid));
            if (o_pending_count !== want.pending)
                report_mismatch("pending_count", KeyW'(o_pending_count), KeyW'(want.pending));
        end
    endtask

    // Result side: check accepted beats, stall in random bursts
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (o_valid && !i_stall) check_result();
            if (stall_left > 0) begin
                stall_left--;
                i_stall <= 1'b1;
            end else if (jitter_on && $urandom_range(0, 11) == 0) begin
                stall_left = $urandom_range(0, 7);
                i_stall <= 1'b1;
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    task automatic idle_input();
        if (valid_hi) begin
            i_valid <= 1'b0;
            valid_hi = 1'b0;
        end
    endtask

    // Drive one beat, wait for it to be taken, then queue its expected result
    task automatic send_beat(t_cmd cmd, logic [KeyW-1:0] raw,
                             bit typed = 1'b0, t_key_result want = '0);
        t_key_result res;
        if (jitter_on && $urandom_range(0, 5) == 0) begin
            idle_input();
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
        end
        i_valid    <= 1'b1;
        valid_hi   = 1'b1;
        i_cmd      <= cmd;
        i_raw_keys <= raw;
        do @(posedge i_clk); while (o_stall);
        res = keypad_predict(cmd, raw);
        due_results.push_back(typed ? want : res);
    endtask

    // Hold the input side until every outstanding result is back
    task automatic wait_all_results();
        idle_input();
        while (due_results.size() != 0) @(posedge i_clk);
    endtask

    // Write all four registers back to back; timer writes carry junk upper bits
    task automatic program_regs(logic [KeyW-1:0] long_m, logic [KeyW-1:0] shift_m,
                                logic [TimerW-1:0] first_d, logic [TimerW-1:0] repeat_p);
        logic [CfgIdxW-1:0] idx_list[4];
        logic [KeyW-1:0]    data_list[4];
        idx_list[0]  = CFG_LONG_MASK;
        idx_list[1]  = CFG_SHIFT_MASK;
        idx_list[2]  = CFG_FIRST_DELAY;
        idx_list[3]  = CFG_REPEAT_PERIOD;
        data_list[0] = long_m;
        data_list[1] = shift_m;
        data_list[2] = {16'($urandom()), first_d};
        data_list[3] = {16'($urandom()), repeat_p};
        for (int i = 0; i < 4; i++) begin
            i_cfg_valid <= 1'b1;
            i_cfg_index <= idx_list[i];
            i_cfg_data  <= data_list[i];
            do @(posedge i_clk); while (!o_cfg_ready);
            case (idx_list[i])
                CFG_LONG_MASK:     cfg_long   = data_list[i];
                CFG_SHIFT_MASK:    cfg_shift  = data_list[i];
                CFG_FIRST_DELAY:   cfg_first  = data_list[i][TimerW-1:0];
                CFG_REPEAT_PERIOD: cfg_repeat = data_list[i][TimerW-1:0];
                default: ;
            endcase
        end
        i_cfg_valid <= 1'b0;
    endtask

    // Key bitmap for one press: plain, shift, long, chords, all keys, noise
    function automatic logic [KeyW-1:0] pick_bitmap();
        logic [KeyW-1:0] bm;
        case ($urandom_range(0, 6))
            0: bm = 32'h1 << $urandom_range(0, 31);
            1: bm = (cfg_shift != '0) ? cfg_shift : 32'h1 << $urandom_range(0, 31);
            2: begin
                bm = cfg_long & $urandom();
                if (bm == '0) bm = cfg_long & (~cfg_long + 32'h1);
                if (bm == '0) bm = 32'h1 << $urandom_range(0, 31);
            end
            3: bm = $urandom() & $urandom() & $urandom();
            4: bm = '1;
            5: bm = $urandom();
            default: bm = (32'h1 << $urandom_range(0, 31)) | (32'h1 << $urandom_range(0, 31));
        endcase
        return bm;
    endfunction

    // Mostly press / hold / release sequences with reads mixed in, some noise
    task automatic run_random_phase(int n_beats);
        int              sent;
        int              span;
        logic [KeyW-1:0] held;
        logic [KeyW-1:0] raw;
        sent = 0;
        while (sent < n_beats) begin
            if ($urandom_range(0, 7) == 0) begin
                repeat ($urandom_range(1, 6)) begin
                    send_beat(t_cmd'($urandom_range(0, 1)), $urandom());
                    sent++;
                end
            end else begin
                held = pick_bitmap();
                span = int'(cfg_first) + 2 * int'(cfg_repeat) + 3;
                if (span > 40) span = 40;
                repeat ($urandom_range(1, span)) begin
                    raw = held;
                    if ($urandom_range(0, 9) == 0) raw = raw ^ (32'h1 << $urandom_range(0, 31));
                    send_beat(CMD_TICK, raw);
                    sent++;
                    if ($urandom_range(0, 2) == 0) begin
                        send_beat(CMD_READ, $urandom());
                        sent++;
                    end
                end
                // full or partial release
                raw = $urandom_range(0, 1) ? '0 : (held & $urandom());
                repeat ($urandom_range(1, 3)) begin
                    send_beat(CMD_TICK, raw);
                    sent++;
                end
            end
            if (jitter_on && $urandom_range(0, 199) == 0) wait_all_results();
        end
        // leave a key held so the next register write lands mid-hold
        held = 32'h1 << $urandom_range(0, 31);
        repeat (3) send_beat(CMD_TICK, held);
    endtask

    task automatic add_row(t_cmd cmd, logic [KeyW-1:0] raw, int reps, bit typed = 1'b0,
                           logic [KeyW-1:0] code = '0, logic ok = 1'b0,
                           logic [CountW-1:0] cnt = '0);
        t_dir_row row;
        row.cmd   = cmd;
        row.raw   = raw;
        row.reps  = 8'(reps);
        row.typed = typed;
        row.want  = '{key_code: code, code_valid: ok, pending: cnt};
        dir_rows.push_back(row);
    endtask

    // Run watchdog
    initial begin
        #(Watchdog);
        $display("simulation failed");
        $finish;
    end

    initial begin : stimulus
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part: long key on bit 31, shift on bit 0, short timers
        program_regs(32'h8000_0000, 32'h0000_0001, 16'd2, 16'd1);
        add_row(CMD_READ, 32'h0,         1, 1'b1);  // read of an empty store
        add_row(CMD_TICK, 32'h0,         1, 1'b1);
        add_row(CMD_TICK, 32'hFFFF_FFFF, 2, 1'b1);  // one sample is not enough
        add_row(CMD_TICK, 32'h0,         1, 1'b1);  // lone glitch keeps keys down
        add_row(CMD_TICK, 32'h0,         1);        // release all, shift toggles
        add_row(CMD_TICK, 32'h0000_0002, 12);       // repeats overflow the store
        add_row(CMD_TICK, 32'h0,         2);        // release after codes: silent
        add_row(CMD_READ, 32'hFFFF_FFFF, 1);
        add_row(CMD_TICK, 32'h8000_0000, 5);        // inverted long code, once
        add_row(CMD_READ, 32'h0,         2);
        foreach (dir_rows[i]) begin
            for (int k = 0; k < int'(dir_rows[i].reps); k++) begin
                send_beat(dir_rows[i].cmd, dir_rows[i].raw, dir_rows[i].typed,
                          dir_rows[i].want);
            end
        end
        wait_all_results();

        // Random phases over a spread of register settings
        program_regs('0, '0, FirstDelayRst, RepeatPeriodRst);
        run_random_phase(PhaseBeats);
        wait_all_results();
        program_regs('1, 32'h0000_0001, 16'd1, 16'd1);
        run_random_phase(PhaseBeats);
        wait_all_results();
        program_regs($urandom(), 32'h1 << $urandom_range(0, 31), 16'd3, 16'd2);
        run_random_phase(PhaseBeats);
        wait_all_results();
        program_regs('0, '1, 16'd1, 16'hFFFF);
        run_random_phase(PhaseBeats);
        wait_all_results();
        program_regs($urandom(), 32'h1 << $urandom_range(0, 31), 16'hFFFF, 16'd1);
        run_random_phase(PhaseBeats);
        wait_all_results();

        // Last stretch runs flat out: no gaps, no stalls
        jitter_on = 1'b0;
        program_regs($urandom(), $urandom(), 16'($urandom_range(1, 6)),
                     16'($urandom_range(1, 4)));
        run_random_phase(PhaseBeats);
        wait_all_results();
        repeat (8) @(posedge i_clk);

        if (mismatch_cnt == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

/* sim.f */
rtl/kdlp_pkg.sv
rtl/kdlp_scan.sv
rtl/keypad_debounce_long_press_fifo.sv
rtl/kdlp_sva.sv
tb/sv/tb_top.sv
